@@ design/uud_pkg.sv @@
// shared types, codes and constants of the utf8/utf16 codepoint decoder
package uud_pkg;

	localparam int DEFAULT_OFFSET_BITS = 16;
	localparam int CHAR_OFFSET_W = 16;
	localparam int CP_W = 21;

	localparam logic [1:0] ENC_ASCII = 2'd0;
	localparam logic [1:0] ENC_UTF8 = 2'd1;
	localparam logic [1:0] ENC_UTF16LE = 2'd2;
	localparam logic [1:0] ENC_UTF16BE = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_INVALID_UTF8 = 3'd1;
	localparam logic [2:0] ST_INCOMPLETE_UTF8 = 3'd2;
	localparam logic [2:0] ST_OVERLONG = 3'd3;
	localparam logic [2:0] ST_ABOVE_MAX = 3'd4;
	localparam logic [2:0] ST_RANGE_TOO_SMALL = 3'd5;
	localparam logic [2:0] ST_INCOMPLETE_UTF16 = 3'd6;
	localparam logic [2:0] ST_BAD_LOW_SURROGATE = 3'd7;

	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD = 2'd2;
	localparam logic [1:0] PH_FOURTH = 2'd3;

	localparam logic [CP_W-1:0] MAX_CP = 21'h10FFFF;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [15:0] bytes_remaining;
	} in_item_t;

	typedef struct packed {
		logic [CP_W-1:0]          codepoint;
		logic [CHAR_OFFSET_W-1:0] char_offset;
		logic [2:0]               char_length;
		logic [2:0]               status;
	} out_item_t;

	typedef struct packed {
		logic [CP_W-1:0] partial_value;
		logic [1:0]      continuation_left;
		logic [1:0]      minimum_class;
		logic [1:0]      byte_phase;
		logic [15:0]     held_word;
	} char_state_t;

	localparam char_state_t CHAR_STATE_CLEAR = '0;

	// smallest value allowed for each utf-8 sequence class
	function automatic logic [CP_W-1:0] min_value(input logic [1:0] cls);
		logic [CP_W-1:0] v;
		unique case (cls)
			2'd0: v = 21'h0;
			2'd1: v = 21'h80;
			2'd2: v = 21'h800;
			default: v = 21'h10000;
		endcase
		return v;
	endfunction

endpackage

@@ design/uud_decode.sv @@
// single-pass decode of one byte: next character state, offsets and result
module uud_decode import uud_pkg::*; #(
	parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
	input  logic [1:0]               text_encoding,
	input  in_item_t                 item,
	input  char_state_t              cs,
	input  logic                     discarding,
	input  logic [OFFSET_BITS-1:0]   range_position,
	input  logic [CHAR_OFFSET_W-1:0] char_start,
	output char_state_t              cs_next,
	output logic                     discarding_next,
	output logic [OFFSET_BITS-1:0]   range_position_next,
	output logic [CHAR_OFFSET_W-1:0] char_start_next,
	output logic                     res_valid,
	output out_item_t                res
);

	logic [7:0]               b;
	logic [15:0]              rem;
	logic                     fin;
	logic [15:0]              left;
	logic [CHAR_OFFSET_W-1:0] cur;
	logic [3:0]               cls;
	logic [1:0]               need;
	logic [CP_W-1:0]          acc;
	logic [2:0]               seen;
	logic [15:0]              w;
	logic [CP_W-1:0]          cp;
	logic [2:0]               len;
	logic [2:0]               st;
	logic                     emit;
	logic                     err;
	logic [CHAR_OFFSET_W-1:0] start;
	char_state_t              nxt;

	always_comb begin
		b = item.byte_value;
		rem = item.bytes_remaining;
		fin = rem <= 16'd1;
		left = (rem == 16'd0) ? 16'd0 : rem - 16'd1;
		cur = CHAR_OFFSET_W'(range_position);
		cls = b[6:3];
		if (cls == 4'd14) begin
			need = 2'd3;
		end else if (cls >= 4'd12) begin
			need = 2'd2;
		end else if (cls >= 4'd8) begin
			need = 2'd1;
		end else begin
			need = 2'd0;
		end
		acc = {cs.partial_value[CP_W-7:0], b[5:0]};
		seen = 3'(cs.minimum_class) + 3'd2 - 3'(cs.continuation_left);
		w = (text_encoding == ENC_UTF16BE) ? {cs.partial_value[7:0], b}
			: {b, cs.partial_value[7:0]};

		cp = '0;
		len = 3'd0;
		st = ST_OK;
		emit = 1'b0;
		err = 1'b0;
		start = char_start;
		nxt = cs;

		if (!discarding) begin
			unique case (text_encoding)
				ENC_ASCII: begin
					start = cur;
					cp = {13'd0, b};
					len = 3'd1;
					emit = 1'b1;
				end
				ENC_UTF8: begin
					if (cs.continuation_left == 2'd0) begin
						start = cur;
						if (!b[7]) begin
							cp = {13'd0, b};
							len = 3'd1;
							emit = 1'b1;
						end else if (need == 2'd0) begin
							err = 1'b1;
							st = ST_INVALID_UTF8;
							len = 3'd1;
						end else if (left < {14'd0, need}) begin
							err = 1'b1;
							st = ST_INCOMPLETE_UTF8;
							len = 3'd1;
						end else begin
							unique case (need)
								2'd3: nxt.partial_value = {18'd0, b[2:0]};
								2'd2: nxt.partial_value = {17'd0, b[3:0]};
								default: nxt.partial_value = {16'd0, b[4:0]};
							endcase
							nxt.continuation_left = need;
							nxt.minimum_class = need;
						end
					end else begin
						if (b[7:6] != 2'b10) begin
							err = 1'b1;
							st = ST_INVALID_UTF8;
							len = seen;
						end else begin
							nxt.partial_value = acc;
							nxt.continuation_left = cs.continuation_left - 2'd1;
							if (cs.continuation_left == 2'd1) begin
								len = 3'(cs.minimum_class) + 3'd1;
								if (acc < min_value(cs.minimum_class)) begin
									err = 1'b1;
									st = ST_OVERLONG;
								end else if (acc > MAX_CP) begin
									err = 1'b1;
									st = ST_ABOVE_MAX;
								end else if (acc >= 21'hD800 && acc <= 21'hDFFF) begin
									err = 1'b1;
									st = ST_INVALID_UTF8;
								end else begin
									cp = acc;
									emit = 1'b1;
								end
							end else if (fin) begin
								err = 1'b1;
								st = ST_INCOMPLETE_UTF8;
								len = seen;
							end
						end
					end
					if (emit || err) begin
						nxt.continuation_left = 2'd0;
						nxt.partial_value = '0;
					end
				end
				default: begin
					unique case (cs.byte_phase)
						PH_FIRST: begin
							start = cur;
							if (left == 16'd0) begin
								err = 1'b1;
								st = ST_RANGE_TOO_SMALL;
								len = 3'd1;
							end else begin
								nxt.partial_value = {13'd0, b};
								nxt.byte_phase = PH_SECOND;
							end
						end
						PH_SECOND: begin
							if (w < 16'hD800 || w > 16'hDFFF) begin
								cp = {5'd0, w};
								len = 3'd2;
								emit = 1'b1;
							end else if (w >= 16'hDC00) begin
								err = 1'b1;
								st = ST_BAD_LOW_SURROGATE;
								len = 3'd2;
							end else if (left < 16'd2) begin
								err = 1'b1;
								st = ST_INCOMPLETE_UTF16;
								len = 3'd2;
							end else begin
								nxt.held_word = w;
								nxt.byte_phase = PH_THIRD;
							end
						end
						PH_THIRD: begin
							nxt.partial_value = {13'd0, b};
							nxt.byte_phase = PH_FOURTH;
							if (fin) begin
								err = 1'b1;
								st = ST_INCOMPLETE_UTF16;
								len = 3'd3;
							end
						end
						default: begin
							len = 3'd4;
							if (w < 16'hDC00 || w > 16'hDFFF) begin
								err = 1'b1;
								st = ST_BAD_LOW_SURROGATE;
							end else begin
								cp = 21'h10000 + {1'b0, cs.held_word[9:0], w[9:0]};
								emit = 1'b1;
							end
						end
					endcase
					if (emit || err) begin
						nxt.byte_phase = PH_FIRST;
						nxt.partial_value = '0;
					end
				end
			endcase
		end

		range_position_next = range_position + OFFSET_BITS'(1);
		discarding_next = discarding;
		if (err) begin
			cp = '0;
			if (!fin) begin
				discarding_next = 1'b1;
			end
		end
		if (fin) begin
			range_position_next = '0;
			discarding_next = 1'b0;
			nxt = CHAR_STATE_CLEAR;
		end

		cs_next = nxt;
		char_start_next = start;
		res_valid = emit || err;
		res.codepoint = cp;
		res.char_offset = start;
		res.char_length = len;
		res.status = st;
	end

endmodule

@@ design/uud_out_reg.sv @@
// result register toward the output channel
module uud_out_reg import uud_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t load_data,
	output logic      free,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      valid_q;
	out_item_t data_q;

	assign free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

@@ design/utf8_utf16_codepoint_decoder_unit.sv @@
// top level of the utf8/utf16 codepoint decoder
//
// in channel: one raw byte per request with the count of bytes left in the
// range (1 marks the final byte). out channel: one result per completed
// character or detected error, carrying codepoint, offset, length, status.
// cfg_we/cfg_wdata write the text encoding (ascii, utf-8, utf-16le/be);
// a write also drops any partly received character. write only when idle.
// an accepted byte sits in the input register, where the
// decode logic updates the character state and loads the result register;
// a result is offered from the result register once its completing byte
// has left the input register. throughput is one byte per clock, set by the
// single decode pass, except while a byte waits for the result register.
// bytes that complete nothing leave the input register even while the
// receiver stalls; a byte with a result waits there until the result
// register frees, and in_ready drops only while both are held.
// reset clears both registers, the character state, the range offset and
// the discard flag, and selects ascii.
module utf8_utf16_codepoint_decoder_unit import uud_pkg::*; #(
	parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	logic                     valid_s1;
	in_item_t                 item_s1;
	logic [1:0]               enc_q;
	char_state_t              cs_q;
	logic                     discarding_q;
	logic [OFFSET_BITS-1:0]   pos_q;
	logic [CHAR_OFFSET_W-1:0] start_q;

	char_state_t              cs_next;
	logic                     discarding_next;
	logic [OFFSET_BITS-1:0]   pos_next;
	logic [CHAR_OFFSET_W-1:0] start_next;
	logic                     res_valid;
	out_item_t                res;
	logic                     out_free;
	logic                     s1_fire;

	uud_decode #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_decode (
		.text_encoding      (enc_q),
		.item               (item_s1),
		.cs                 (cs_q),
		.discarding         (discarding_q),
		.range_position     (pos_q),
		.char_start         (start_q),
		.cs_next            (cs_next),
		.discarding_next    (discarding_next),
		.range_position_next(pos_next),
		.char_start_next    (start_next),
		.res_valid          (res_valid),
		.res                (res)
	);

	uud_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s1_fire && res_valid),
		.load_data(res),
		.free     (out_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	assign s1_fire = valid_s1 && (!res_valid || out_free);
	assign in_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q <= ENC_ASCII;
			cs_q <= CHAR_STATE_CLEAR;
			discarding_q <= 1'b0;
			pos_q <= '0;
			start_q <= '0;
		end else if (cfg_we) begin
			enc_q <= cfg_wdata;
			cs_q <= CHAR_STATE_CLEAR;
		end else if (s1_fire) begin
			cs_q <= cs_next;
			discarding_q <= discarding_next;
			pos_q <= pos_next;
			start_q <= start_next;
		end
	end

endmodule
